### rtl/tsts_pkg.sv
// Shared types, constants and control structures for the time-slice task scheduler.
package tsts_pkg;

    // Slot table geometry.
    localparam int NUM_SLOTS   = 8;
    localparam int SLOT_W      = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int OUT_SLOT_W  = 3;
    localparam int SLEEP_W     = 16;
    localparam int SLICE_W     = 8;
    localparam int CMD_W       = 2;

    localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
    localparam logic [SLICE_W-1:0] SLICE_MAX   = 8'd255;
    localparam logic [SLOT_W-1:0]  LAST_SLOT   = SLOT_W'(NUM_SLOTS - 1);

    // Per-slot scheduling state.
    typedef enum logic [1:0] {
        ST_DEAD     = 2'd0,
        ST_RUNNABLE = 2'd1,
        ST_RUNNING  = 2'd2,
        ST_BLOCKED  = 2'd3
    } slot_state_t;

    // Command codes carried on the input channel.
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_SLEEP = 2'd1,
        CMD_EXIT  = 2'd2,
        CMD_FORK  = 2'd3
    } cmd_t;

    // Which slot the datapath touches in the current cycle.
    typedef enum logic [1:0] {
        ADDR_WALK = 2'd0,
        ADDR_CUR  = 2'd1,
        ADDR_PICK = 2'd2
    } addr_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              idle;
        logic              load;
        logic              prep;
        logic              walk;
        logic              slice;
        logic              pick;
        logic              fork_step;
        logic              finish;
        addr_sel_t         addr_sel;
        logic [SLOT_W-1:0] walk_idx;
    } dp_ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        cmd_t cmd;
        logic dead_here;
        logic expired;
        logic out_busy;
    } dp_status_t;

endpackage

### rtl/time_slice_task_scheduler.sv
// A tick walks the slot table, one slot per cycle, then updates the current slot's
// slice and, when it expires, picks the highest runnable slot; sleep and exit first
// mark the current slot, and a fork scans for the first dead slot. A new command is
// accepted only while idle, once the previous result is in the output register.
// Reset (aresetn low, synchronous): slot 0 running, other slots dead, counters zero,
// slice length 10, no result pending.
module time_slice_task_scheduler
    import tsts_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // [15:0] sleep_ticks
    input  logic [1:0]  s_tuser,  // [1:0] cmd
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,  // [2:0] running_slot, [5:3] child_slot, [7:6] zero
    output logic [1:0]  m_tuser,  // [0] switched, [1] fork_ok
    // Slice length register.
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata
);

    dp_ctl_t               ctl;
    dp_status_t            status;
    logic [OUT_SLOT_W-1:0] run_slot, child_slot;
    logic                  switched, fork_ok;

    tsts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .ctl      (ctl)
    );

    tsts_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctl              (ctl),
        .status           (status),
        .in_cmd           (s_tuser),
        .in_ticks         (s_tdata),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_running_slot (run_slot),
        .out_switched     (switched),
        .out_fork_ok      (fork_ok),
        .out_child_slot   (child_slot)
    );

    // Pack the result fields.
    assign m_tdata = {2'b00, child_slot, run_slot};
    assign m_tuser = {fork_ok, switched};

endmodule

### rtl/tsts_ctrl.sv
// Sequencing state machine for the time-slice task scheduler.
module tsts_ctrl
    import tsts_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_ctl_t    ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_WALK  = 7'b0000100,
        S_SLICE = 7'b0001000,
        S_PICK  = 7'b0010000,
        S_FORK  = 7'b0100000,
        S_DONE  = 7'b1000000
    } ctrl_state_t;

    ctrl_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] idx_reg, idx_next;
    logic              accept;

    assign accept   = (state_reg == S_IDLE) && s_tvalid;
    assign s_tready = (state_reg == S_IDLE);

    // Next-state and walk counter logic.
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_IDLE: begin
                idx_next = '0;
                if (s_tvalid) begin
                    unique case (status.cmd)
                        CMD_TICK:  state_next = S_WALK;
                        CMD_SLEEP,
                        CMD_EXIT:  state_next = S_PREP;
                        CMD_FORK:  state_next = S_FORK;
                        default:   state_next = S_WALK;
                    endcase
                end
            end
            S_PREP: state_next = S_WALK;
            S_WALK: begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == LAST_SLOT) begin
                    state_next = S_SLICE;
                end
            end
            S_SLICE: state_next = status.expired ? S_PICK : S_DONE;
            S_PICK:  state_next = S_DONE;
            S_FORK: begin
                idx_next = idx_reg + 1'b1;
                if (status.dead_here || (idx_reg == LAST_SLOT)) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!status.out_busy) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Command outputs to the datapath.
    always_comb begin
        ctl.idle      = (state_reg == S_IDLE);
        ctl.load      = accept;
        ctl.prep      = (state_reg == S_PREP);
        ctl.walk      = (state_reg == S_WALK);
        ctl.slice     = (state_reg == S_SLICE);
        ctl.pick      = (state_reg == S_PICK);
        ctl.fork_step = (state_reg == S_FORK);
        ctl.finish    = (state_reg == S_DONE) && !status.out_busy;
        ctl.walk_idx  = idx_reg;
        unique case (state_reg)
            S_PREP,
            S_SLICE: ctl.addr_sel = ADDR_CUR;
            S_PICK:  ctl.addr_sel = ADDR_PICK;
            default: ctl.addr_sel = ADDR_WALK;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // The state register always holds exactly one active state.
    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("controller state is not one-hot");

    // A finished result waits while the previous one has not been taken.
    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DONE) && status.out_busy |=> (state_reg == S_DONE))
        else $error("result completed while output register was full");

    // A walk always starts from slot zero.
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (idx_reg == '0))
        else $error("walk counter not cleared on a new transaction");

endmodule

### rtl/tsts_dp.sv
// Slot table, pick logic and result register for the time-slice task scheduler.
module tsts_dp
    import tsts_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_ctl_t               ctl,
    output dp_status_t            status,
    input  logic [CMD_W-1:0]      in_cmd,
    input  logic [SLEEP_W-1:0]    in_ticks,
    input  logic                  cfg_we,
    input  logic [SLICE_W-1:0]    cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_SLOT_W-1:0] out_running_slot,
    output logic                  out_switched,
    output logic                  out_fork_ok,
    output logic [OUT_SLOT_W-1:0] out_child_slot
);

    // Slot table, one entry touched per cycle.
    slot_state_t       state_reg [NUM_SLOTS];
    slot_state_t       state_next[NUM_SLOTS];
    logic [SLEEP_W-1:0] sleep_reg [NUM_SLOTS];
    logic [SLEEP_W-1:0] sleep_next[NUM_SLOTS];
    logic [SLICE_W-1:0] slice_reg [NUM_SLOTS];
    logic [SLICE_W-1:0] slice_next[NUM_SLOTS];

    // Per-transaction working registers.
    cmd_t               cmd_reg, cmd_next;
    logic [SLEEP_W-1:0] ticks_reg, ticks_next;
    logic [SLOT_W-1:0]  cur_reg, cur_next;
    logic [SLOT_W-1:0]  pick_reg, pick_next;
    logic               switched_reg, switched_next;
    logic               fork_ok_reg, fork_ok_next;
    logic [SLOT_W-1:0]  child_reg, child_next;
    logic [SLICE_W-1:0] slice_len_reg;

    // Output register.
    logic                  m_valid_reg;
    logic [OUT_SLOT_W-1:0] m_run_reg, m_child_reg;
    logic                  m_sw_reg, m_fork_reg;

    logic [SLOT_W-1:0]  addr;
    slot_state_t        st;
    logic [SLEEP_W-1:0] sl;
    logic [SLICE_W-1:0] sc;
    logic [SLEEP_W-1:0] sl_dec;
    slot_state_t        walk_st;
    logic [SLICE_W-1:0] sc_inc;
    logic               expired;

    // Address selection and read of the addressed entry.
    always_comb begin
        case (ctl.addr_sel)
            ADDR_CUR:  addr = cur_reg;
            ADDR_PICK: addr = pick_reg;
            default:   addr = ctl.walk_idx;
        endcase
        st      = state_reg[addr];
        sl      = sleep_reg[addr];
        sc      = slice_reg[addr];
        sl_dec  = sl - 1'b1;
        walk_st = st;
        if (st == ST_BLOCKED && sl_dec == '0) begin
            walk_st = ST_RUNNABLE;
        end
        sc_inc  = (sc == SLICE_MAX) ? sc : sc + 1'b1;
        expired = (sc_inc >= slice_len_reg);
    end

    assign status.cmd       = (ctl.idle) ? cmd_t'(in_cmd) : cmd_reg;
    assign status.dead_here = (st == ST_DEAD);
    assign status.expired   = expired;
    assign status.out_busy  = m_valid_reg && !out_ready;

    // Slot table and working register updates.
    always_comb begin
        state_next    = state_reg;
        sleep_next    = sleep_reg;
        slice_next    = slice_reg;
        cmd_next      = cmd_reg;
        ticks_next    = ticks_reg;
        cur_next      = cur_reg;
        pick_next     = pick_reg;
        switched_next = switched_reg;
        fork_ok_next  = fork_ok_reg;
        child_next    = child_reg;

        if (ctl.load) begin
            cmd_next      = cmd_t'(in_cmd);
            ticks_next    = in_ticks;
            pick_next     = '0;
            switched_next = 1'b0;
            fork_ok_next  = 1'b0;
            child_next    = '0;
        end

        // Sleep or exit marks the current slot and forces its slice to expire.
        if (ctl.prep) begin
            if (cmd_reg == CMD_SLEEP) begin
                state_next[addr] = ST_BLOCKED;
                sleep_next[addr] = ticks_reg;
            end else begin
                state_next[addr] = ST_DEAD;
            end
            slice_next[addr] = slice_len_reg;
        end

        // Countdown of blocked slots; remember the highest runnable slot.
        if (ctl.walk) begin
            if (st == ST_BLOCKED) begin
                sleep_next[addr] = sl_dec;
            end
            state_next[addr] = walk_st;
            if (walk_st == ST_RUNNABLE) begin
                pick_next = addr;
            end
        end

        // Slice accounting of the current slot.
        if (ctl.slice) begin
            if (!expired) begin
                slice_next[addr] = sc_inc;
            end else begin
                slice_next[addr] = '0;
                switched_next    = 1'b1;
                if (pick_reg == addr) begin
                    state_next[addr] = ST_RUNNING;
                end else if (st == ST_RUNNING) begin
                    state_next[addr] = ST_RUNNABLE;
                end
            end
        end

        // The picked slot takes over.
        if (ctl.pick) begin
            state_next[addr] = ST_RUNNING;
            cur_next         = addr;
        end

        // Fork claims the first dead slot found.
        if (ctl.fork_step && st == ST_DEAD) begin
            state_next[addr] = ST_RUNNABLE;
            slice_next[addr] = '0;
            sleep_next[addr] = '0;
            fork_ok_next     = 1'b1;
            child_next       = addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                state_reg[i] <= (i == 0) ? ST_RUNNING : ST_DEAD;
                sleep_reg[i] <= '0;
                slice_reg[i] <= '0;
            end
            cur_reg       <= '0;
            slice_len_reg <= SLICE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            sleep_reg <= sleep_next;
            slice_reg <= slice_next;
            cur_reg   <= cur_next;
            if (cfg_we) begin
                slice_len_reg <= cfg_wdata;
            end
            if (ctl.finish) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        ticks_reg    <= ticks_next;
        pick_reg     <= pick_next;
        switched_reg <= switched_next;
        fork_ok_reg  <= fork_ok_next;
        child_reg    <= child_next;
        if (ctl.finish) begin
            m_run_reg   <= OUT_SLOT_W'(cur_reg);
            m_sw_reg    <= switched_reg;
            m_fork_reg  <= fork_ok_reg;
            m_child_reg <= OUT_SLOT_W'(child_reg);
        end
    end

    assign out_valid        = m_valid_reg;
    assign out_running_slot = m_run_reg;
    assign out_switched     = m_sw_reg;
    assign out_fork_ok      = m_fork_reg;
    assign out_child_slot   = m_child_reg;

    // Between transactions the current slot is always the one marked running.
    a_cur_running: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.idle |-> (state_reg[cur_reg] == ST_RUNNING))
        else $error("current slot is not in the running state");

    // A fork never runs a tick, so it never reports a switch.
    a_fork_no_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl.finish && fork_ok_reg |-> !switched_reg)
        else $error("fork reported a slot switch");

    // The current slot changes only through a pick.
    a_cur_by_pick: assert property (@(posedge aclk) disable iff (!aresetn)
        !ctl.pick |=> $stable(cur_reg))
        else $error("current slot changed outside a pick");

endmodule
